// ===== rtl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Types, fixed-point constants and small helpers for the Pt100 resistance to
// temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DSETUP,
        ST_DRUN,
        ST_DFIN,
        ST_MRUN,
        ST_MFIN,
        ST_OUT
    } state_t;

    // internal Q32 temperature / ohms, Q60 coefficients
    localparam int IFRAC      = 32;
    localparam int TW         = 44;
    localparam int DIV_SHIFT  = 4;   // 64 - 60

    localparam logic signed [63:0] TEMP_LIMIT = 64'sd1024 <<< IFRAC;
    localparam logic signed [63:0] OHM100     = 64'sd100 <<< IFRAC;
    localparam logic signed [63:0] CF_A1      = 64'sd450596311645494004;
    localparam logic signed [63:0] CF_A2      = -64'sd66581216893355;
    localparam logic signed [63:0] CF_A3      = 64'sd48226706538;
    localparam logic signed [63:0] CF_A4      = -64'sd482267065;
    localparam logic signed [63:0] CF_D2      = -64'sd133162433786711;
    localparam logic signed [63:0] CF_D3      = 64'sd144680119613;
    localparam logic signed [63:0] CF_D4      = -64'sd1929068262;

    localparam logic signed [44:0] OUT_MAX = 45'sd67108863;
    localparam logic signed [44:0] OUT_MIN = -45'sd67108864;

    // horner step sequence: ops 0..3 build f, ops 4..6 build df
    localparam logic [2:0] OP_F_LAST = 3'd3;
    localparam logic [2:0] OP_LAST   = 3'd6;

    localparam logic [7:0] REG_TOL   = 8'd0;
    localparam logic [7:0] REG_ITER  = 8'd1;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // sign * min(m, 2^62)
    function automatic logic signed [63:0] sign_sat(input logic [127:0] m, input logic neg);
        logic        big;
        logic [62:0] mm;
        big = (m[127:63] != '0) || (m[62] && (m[61:0] != '0));
        mm  = big ? {1'b1, 62'b0} : m[62:0];
        return neg ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
    endfunction

    function automatic logic signed [63:0] addend(input logic [2:0] op, input logic quartic);
        logic signed [63:0] r;
        case (op)
            3'd0:    r = quartic ? CF_A3 : 64'sd0;
            3'd1:    r = CF_A2;
            3'd2:    r = CF_A1;
            3'd3:    r = OHM100;
            3'd4:    r = quartic ? CF_D3 : 64'sd0;
            3'd5:    r = CF_D2;
            3'd6:    r = CF_A1;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [TW-1:0] clamp_temp(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > TEMP_LIMIT) begin
            c = TEMP_LIMIT;
        end else if (v < -TEMP_LIMIT) begin
            c = -TEMP_LIMIT;
        end else begin
            c = v;
        end
        return c[TW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtd_resistance_to_temperature.sv =====
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature
// Pt100 resistance to temperature by Newton iteration on the Callendar-Van
// Dusen curve, one shared 32x32 multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// range error goes straight to the output; else a start divide, then N Newton steps,
//   each step 7 horner products and a divide
// handshake: one item at a time, s_tready low until the result is registered
// the divider is a 64-step restoring divider, the multiplier a 4-phase multiplier
// reset: synchronous active-low aresetn, step_tolerance 66, max_iterations 50
`default_nettype none

module rtd_resistance_to_temperature #(
    parameter int FRAC_BITS     = 16,
    parameter int ITERATION_CAP = 63
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [24:0] resistance
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [26:0] temperature, [32:27] steps_used
    output logic [1:0]  m_tuser,   // [0] range_error, [1] converged
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int TW    = rtd_pkg::TW;
    localparam int SHIFT = rtd_pkg::IFRAC - FRAC_BITS;
    localparam logic [63:0] LOW_BOUND  = ((64'd1852 << FRAC_BITS) + 64'd99) / 64'd100;
    localparam logic [63:0] HIGH_BOUND = (64'd39048 << FRAC_BITS) / 64'd100;
    localparam logic [63:0] RES_100    = 64'd100 << FRAC_BITS;
    localparam logic [63:0] ERR_RAW    = 64'd1000 << FRAC_BITS;
    localparam logic [26:0] ERR_TEMP   =
        (ERR_RAW > 64'd67108863) ? 27'h3ffffff : ERR_RAW[26:0];
    localparam logic [8:0]  CAP9       = 9'(ITERATION_CAP);

    rtd_pkg::state_t state_reg, state_next;

    logic [15:0]          tol_reg, tol_next;
    logic [5:0]           maxit_reg, maxit_next;
    logic [63:0]          r32_reg, r32_next;
    logic                 quartic_reg, quartic_next;
    logic [5:0]           limit_reg, limit_next;
    logic [5:0]           steps_reg, steps_next;
    logic                 conv_reg, conv_next;
    logic                 err_reg, err_next;
    logic                 init_reg, init_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic signed [63:0]   acc_reg, acc_next;
    logic signed [63:0]   f_reg, f_next;
    logic [2:0]           op_reg, op_next;
    logic [1:0]           phase_reg, phase_next;
    logic [127:0]         prod_reg, prod_next;
    logic [63:0]          rem_reg, rem_next;
    logic [63:0]          lo_reg, lo_next;
    logic [63:0]          q_reg, q_next;
    logic [63:0]          ud_reg, ud_next;
    logic                 dneg_reg, dneg_next;
    logic [5:0]           dcnt_reg, dcnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic               in_xfer;
    logic [63:0]        r_in;
    logic               in_range;
    logic [5:0]         limit_w;
    logic signed [63:0] dn, dd;
    logic [63:0]        un, ud;
    logic [63:0]        rem_sh;
    logic               take;
    logic signed [63:0] dres;
    logic signed [63:0] tsum;
    logic signed [TW-1:0] nt;
    logic signed [TW:0] diff;
    logic [TW:0]        adiff;
    logic [63:0]        tol32;
    logic [63:0]        ma, mb;
    logic [31:0]        ca, cb;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic [127:0]       shifted;
    logic signed [63:0] mres, acc_new;
    logic signed [TW:0] rv, rs;
    logic [26:0]        temp_out;
    logic [5:0]         steps_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rtd_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign in_xfer   = s_tvalid && s_tready;

    assign r_in     = {39'b0, s_tdata[24:0]};
    assign in_range = (r_in >= LOW_BOUND) && (r_in <= HIGH_BOUND);
    assign limit_w  = ({3'b0, maxit_reg} > CAP9) ? CAP9[5:0] : maxit_reg;

    // divider operands
    assign dn = init_reg ? $signed(r32_reg) - rtd_pkg::OHM100 : $signed(r32_reg) - f_reg;
    assign dd = init_reg ? rtd_pkg::CF_A1 : acc_reg;
    assign un = rtd_pkg::mag64(dn);
    assign ud = rtd_pkg::mag64(dd);
    assign rem_sh = {rem_reg[62:0], lo_reg[63]};
    assign take   = rem_reg[63] || (rem_sh >= ud_reg);
    assign dres   = rtd_pkg::sign_sat({64'b0, q_reg}, dneg_reg);

    assign tsum  = 64'(t_reg) + dres;
    assign nt    = rtd_pkg::clamp_temp(tsum);
    assign diff  = (TW+1)'(nt) - (TW+1)'(t_reg);
    assign adiff = diff[TW] ? (TW+1)'(-diff) : (TW+1)'(diff);
    assign tol32 = {48'b0, tol_reg} << SHIFT;

    // shared multiplier, one 32x32 partial product a cycle while in ST_MRUN
    assign ma    = rtd_pkg::mag64(64'(t_reg));
    assign mb    = rtd_pkg::mag64(acc_reg);
    assign ca    = phase_reg[1] ? ma[63:32] : ma[31:0];
    assign cb    = phase_reg[0] ? mb[63:32] : mb[31:0];
    assign pp    = 64'(ca) * 64'(cb);
    always_comb begin
        case (phase_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
    end
    assign shifted = (op_reg == rtd_pkg::OP_F_LAST) ? (prod_reg >> 60) : (prod_reg >> 32);
    assign mres    = rtd_pkg::sign_sat(shifted, t_reg[TW-1] ^ acc_reg[63]);
    assign acc_new = rtd_pkg::addend(op_reg, quartic_reg) + mres;

    // output rounding, halves up
    assign rv = (TW+1)'(t_reg) + ((TW+1)'(1) <<< (SHIFT - 1));
    assign rs = rv >>> SHIFT;
    assign temp_out = (rs > rtd_pkg::OUT_MAX) ? rtd_pkg::OUT_MAX[26:0] :
                      (rs < rtd_pkg::OUT_MIN) ? rtd_pkg::OUT_MIN[26:0] : rs[26:0];
    assign steps_inc = steps_reg + 6'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = in_range ? rtd_pkg::ST_DSETUP : rtd_pkg::ST_OUT;
                end
            end
            rtd_pkg::ST_DSETUP: begin
                if (ud == '0 || ({4'b0, un[63:4]} >= ud)) begin
                    state_next = rtd_pkg::ST_DFIN;
                end else begin
                    state_next = rtd_pkg::ST_DRUN;
                end
            end
            rtd_pkg::ST_DRUN: begin
                if (dcnt_reg == 6'd63) begin
                    state_next = rtd_pkg::ST_DFIN;
                end
            end
            rtd_pkg::ST_DFIN: begin
                if (init_reg) begin
                    state_next = (limit_reg == '0) ? rtd_pkg::ST_OUT : rtd_pkg::ST_MRUN;
                end else if ((64'(adiff) < tol32) || (steps_inc == limit_reg)) begin
                    state_next = rtd_pkg::ST_OUT;
                end else begin
                    state_next = rtd_pkg::ST_MRUN;
                end
            end
            rtd_pkg::ST_MRUN: begin
                if (phase_reg == 2'd3) begin
                    state_next = rtd_pkg::ST_MFIN;
                end
            end
            rtd_pkg::ST_MFIN: begin
                state_next = (op_reg == rtd_pkg::OP_LAST) ? rtd_pkg::ST_DSETUP
                                                          : rtd_pkg::ST_MRUN;
            end
            rtd_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = rtd_pkg::ST_IDLE;
                end
            end
            default: state_next = rtd_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        tol_next      = tol_reg;
        maxit_next    = maxit_reg;
        r32_next      = r32_reg;
        quartic_next  = quartic_reg;
        limit_next    = limit_reg;
        steps_next    = steps_reg;
        conv_next     = conv_reg;
        err_next      = err_reg;
        init_next     = init_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        f_next        = f_reg;
        op_next       = op_reg;
        phase_next    = phase_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        lo_next       = lo_reg;
        q_next        = q_reg;
        ud_next       = ud_reg;
        dneg_next     = dneg_reg;
        dcnt_next     = dcnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == rtd_pkg::REG_TOL) begin
                tol_next = cfg_data;
            end else if (cfg_index == rtd_pkg::REG_ITER) begin
                maxit_next = cfg_data[5:0];
            end
        end

        case (state_reg)
            rtd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    r32_next     = r_in << SHIFT;
                    quartic_next = r_in < RES_100;
                    limit_next   = limit_w;
                    steps_next   = '0;
                    conv_next    = 1'b0;
                    err_next     = !in_range;
                    init_next    = 1'b1;
                end
            end
            rtd_pkg::ST_DSETUP: begin
                ud_next   = ud;
                dneg_next = dn[63] ^ dd[63];
                rem_next  = {4'b0, un[63:4]};
                lo_next   = {un[3:0], 60'b0};
                dcnt_next = '0;
                if (ud == '0) begin
                    q_next = '0;
                end else if ({4'b0, un[63:4]} >= ud) begin
                    q_next = {2'b01, 62'b0};
                end else begin
                    q_next = '0;
                end
            end
            rtd_pkg::ST_DRUN: begin
                rem_next  = take ? rem_sh - ud_reg : rem_sh;
                lo_next   = {lo_reg[62:0], 1'b0};
                q_next    = {q_reg[62:0], take};
                dcnt_next = dcnt_reg + 6'd1;
            end
            rtd_pkg::ST_DFIN: begin
                acc_next   = quartic_reg ? rtd_pkg::CF_A4 : 64'sd0;
                op_next    = '0;
                phase_next = '0;
                prod_next  = '0;
                init_next  = 1'b0;
                if (init_reg) begin
                    t_next = rtd_pkg::clamp_temp(dres);
                end else begin
                    t_next     = nt;
                    steps_next = steps_inc;
                    conv_next  = 64'(adiff) < tol32;
                end
            end
            rtd_pkg::ST_MRUN: begin
                prod_next  = prod_reg + pp_sh;
                phase_next = phase_reg + 2'd1;
            end
            rtd_pkg::ST_MFIN: begin
                prod_next  = '0;
                phase_next = '0;
                op_next    = op_reg + 3'd1;
                if (op_reg == rtd_pkg::OP_F_LAST) begin
                    f_next   = acc_new;
                    acc_next = quartic_reg ? rtd_pkg::CF_D4 : 64'sd0;
                end else begin
                    acc_next = acc_new;
                end
            end
            rtd_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (err_reg) begin
                        m_tdata_next = {7'b0, 6'b0, ERR_TEMP};
                        m_tuser_next = 2'b01;
                    end else begin
                        m_tdata_next = {7'b0, steps_reg, temp_out};
                        m_tuser_next = {conv_reg, 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rtd_pkg::ST_IDLE;
            tol_reg      <= 16'd66;
            maxit_reg    <= 6'd50;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tol_reg      <= tol_next;
            maxit_reg    <= maxit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r32_reg     <= r32_next;
        quartic_reg <= quartic_next;
        limit_reg   <= limit_next;
        steps_reg   <= steps_next;
        conv_reg    <= conv_next;
        err_reg     <= err_next;
        init_reg    <= init_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        f_reg       <= f_next;
        op_reg      <= op_next;
        phase_reg   <= phase_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        q_reg       <= q_next;
        ud_reg      <= ud_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while conversion in progress");

    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[32:27] == 6'd0 && !m_tuser[1]))
        else $error("range error result carries steps or converged");

    a_conv_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[32:27] != 6'd0))
        else $error("converged result with no steps");

endmodule

`default_nettype wire
